@@ sv/sonde_frame_descramble_checksum_assert.svh @@
// Assertion macros shared by the descrambler and checksum modules.
`ifndef SONDE_FRAME_DESCRAMBLE_CHECKSUM_ASSERT_SVH
`define SONDE_FRAME_DESCRAMBLE_CHECKSUM_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SFDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define SFDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/sfdc_pkg.sv @@
// Types, constants and checksum step shared by the descrambler modules.
`default_nettype none
package sfdc_pkg;

    localparam logic [7:0] FRAME_LEN_RESET = 8'd70;
    localparam logic [7:0] FRAME_LEN_MIN   = 8'd4;
    localparam logic [7:0] SCRAMBLE_MASK   = 8'hFF;
    localparam logic [7:0] LOW6_MASK       = 8'h3F;

    // What the back end does with a byte
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_RX_HIGH = 2'd1,
        KIND_FINAL   = 2'd2
    } t_kind;

    // One classified byte on its way from front to back
    typedef struct packed {
        logic [7:0] plain;
        t_kind      kind;
        logic       clr;
    } t_item;

    // One rotate/XOR step of the running checksum
    function automatic logic [15:0] sum_step(input logic [15:0] c, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] t;
        logic [7:0] s;
        x = {b[0], b[7:1]};
        x = x ^ (x >> 2);
        t = {c[1] ^ c[3] ^ c[5], c[0] ^ c[2] ^ c[4], c[5:0] & LOW6_MASK[5:0]};
        s = c[14:7];
        s = s ^ (s >> 2);
        return {c[7:0], x ^ t ^ s};
    endfunction

endpackage
`default_nettype wire

@@ sv/sonde_frame_descramble_checksum.sv @@
// Input beats pass through a two-entry queue and then the back end's output register.
// Throughput: one byte per cycle unless the queue is full, even while a result waits.
// The front end holds position and chaining bit, the back end the 16-bit running checksum.
// Reset (synchronous, active low) restores frame_length 70 and clears all frame state.
// Top level of the frame descrambler and checksum checker.
`default_nettype none
module sonde_frame_descramble_checksum (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,   // frame_length
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,  // [7:0] raw_byte
    input  wire logic       i_s_axis_tuser,  // [0] frame_start
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,  // [7:0] plain_byte
    output logic            o_m_axis_tlast,  // last_of_frame
    output logic            o_m_axis_tuser   // [0] checksum_good
);
    import sfdc_pkg::*;

    t_item front_item;
    t_item q_item;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;
    logic  in_accept;

    assign o_s_axis_tready = q_ready;
    assign in_accept       = i_s_axis_tvalid && q_ready;

    sfdc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_raw_byte    (i_s_axis_tdata),
        .i_frame_start (i_s_axis_tuser),
        .o_item        (front_item)
    );

    sfdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    sfdc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_plain   (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .o_good    (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ sv/sfdc_front.sv @@
// Front end: accept raw bytes, descramble them and classify by frame position.
`default_nettype none
module sfdc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [7:0]     i_cfg_wr_data,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_raw_byte,
    input  wire logic           i_frame_start,
    output sfdc_pkg::t_item     o_item
);
    import sfdc_pkg::*;

    logic [7:0] r_frame_len;
    logic [7:0] r_pos, n_pos;
    logic       r_prev, n_prev;
    logic [7:0] len_eff;
    logic [7:0] pos_eff;
    logic       prev_eff;
    logic       is_final;
    logic       is_payload;

    // Clamp the configured length and restart the frame on frame_start
    always_comb begin
        len_eff    = (r_frame_len < FRAME_LEN_MIN) ? FRAME_LEN_MIN : r_frame_len;
        pos_eff    = i_frame_start ? 8'd0 : r_pos;
        prev_eff   = i_frame_start ? 1'b0 : r_prev;
        is_final   = ({1'b0, pos_eff} + 9'd1) >= {1'b0, len_eff};
        is_payload = ({1'b0, pos_eff} + 9'd2) < {1'b0, len_eff};
    end

    // Descramble and tag the byte
    always_comb begin
        o_item.plain = i_raw_byte ^ SCRAMBLE_MASK ^ {prev_eff, i_raw_byte[7:1]};
        o_item.clr   = i_frame_start;
        priority if (is_final) begin
            o_item.kind = KIND_FINAL;
        end else if (is_payload) begin
            o_item.kind = KIND_PAYLOAD;
        end else begin
            o_item.kind = KIND_RX_HIGH;
        end
    end

    // Advance position and chaining bit; drop both after the final byte
    always_comb begin
        n_pos  = is_final ? 8'd0 : pos_eff + 8'd1;
        n_prev = is_final ? 1'b0 : i_raw_byte[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RESET;
            r_pos       <= 8'd0;
            r_prev      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_len <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_pos  <= n_pos;
                r_prev <= n_prev;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/sfdc_queue.sv @@
// Two-entry queue between the front and back ends.
`default_nettype none
`include "sonde_frame_descramble_checksum_assert.svh"
module sfdc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sfdc_pkg::t_item i_item,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_valid,
    output sfdc_pkg::t_item     o_item
);
    import sfdc_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count, n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Hold entry data
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    `SFDC_ASSERT(a_no_overfill, i_clk, i_rst_n, (r_count != 2'd3), "queue count out of range")
    `SFDC_ASSERT(a_no_pop_empty, i_clk, i_rst_n, (i_pop |-> r_count != 2'd0), "pop from empty queue")
    `SFDC_ASSERT(a_ptr_gap, i_clk, i_rst_n, ((r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr), "queue pointers disagree with count")

endmodule
`default_nettype wire

@@ sv/sfdc_back.sv @@
// Back end: run the checksum, compare it on the final byte and hold the result beat.
`default_nettype none
`include "sonde_frame_descramble_checksum_assert.svh"
module sfdc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire sfdc_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_plain,
    output logic                o_last,
    output logic                o_good
);
    import sfdc_pkg::*;

    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_rx_high, n_rx_high;
    logic        r_valid;
    logic [7:0]  r_plain;
    logic        r_last, n_last;
    logic        r_good, n_good;
    logic [15:0] sum_eff;
    logic [7:0]  rx_high_eff;
    logic        take;

    // Take a beat when the output register is free or draining
    assign take    = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = take;

    // Update checksum state by byte kind
    always_comb begin
        sum_eff     = i_q_item.clr ? 16'd0 : r_sum;
        rx_high_eff = i_q_item.clr ? 8'd0 : r_rx_high;
        n_sum       = sum_eff;
        n_rx_high   = rx_high_eff;
        n_last      = 1'b0;
        n_good      = 1'b0;
        unique case (i_q_item.kind)
            KIND_PAYLOAD: begin
                n_sum = sum_step(sum_eff, i_q_item.plain);
            end
            KIND_RX_HIGH: begin
                n_rx_high = i_q_item.plain;
            end
            KIND_FINAL: begin
                n_last    = 1'b1;
                n_good    = ({rx_high_eff, i_q_item.plain} == sum_eff);
                n_sum     = 16'd0;
                n_rx_high = 8'd0;
            end
            default: begin
                n_sum = sum_eff;
            end
        endcase
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_plain <= i_q_item.plain;
            r_last  <= n_last;
            r_good  <= n_good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_sum     <= 16'd0;
            r_rx_high <= 8'd0;
        end else begin
            if (take) begin
                r_valid   <= 1'b1;
                r_sum     <= n_sum;
                r_rx_high <= n_rx_high;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_plain = r_plain;
    assign o_last  = r_last;
    assign o_good  = r_good;

    `SFDC_ASSERT(a_good_on_last, i_clk, i_rst_n, ((r_valid && r_good) |-> r_last), "checksum flag off the final byte")
    `SFDC_ASSERT(a_clear_after_final, i_clk, i_rst_n, ((take && i_q_item.kind == KIND_FINAL) |=> (r_sum == 16'd0 && r_rx_high == 8'd0)), "checksum state not cleared after final byte")
    `SFDC_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n |=> !r_valid), "output valid after reset")

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the frame descrambler and checksum checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfdc_pkg::FRAME_LEN_RESET;
    import sfdc_pkg::FRAME_LEN_MIN;
    import sfdc_pkg::SCRAMBLE_MASK;

    localparam int QUIET_LIMIT  = 2000;  // cycles without any beat before giving up
    localparam int HOLD_CYCLES  = 40;    // long receiver stall for the backpressure test
    localparam int DRAIN_CYCLES = 3;     // idle cycles allowed after the last expected result
    localparam int MAX_REPORTS  = 10;

    // One descrambled byte as the block reports it
    typedef struct packed {
        logic [7:0] plain;
        logic       last;
        logic       good;
    } t_result;

    // DUT inputs, all known from time zero
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       cfg_en    = 1'b0;
    logic [7:0] cfg_data  = 8'd0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_data    = 8'd0;
    logic       s_user    = 1'b0;
    logic       m_ready   = 1'b0;

    // DUT outputs
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic       o_m_axis_tuser;

    // Predictor copy of the frame state and the length register
    logic [7:0]  len_reg   = FRAME_LEN_RESET;
    logic        chain_bit = 1'b0;
    logic [15:0] sum_acc   = 16'd0;
    logic [7:0]  pos_cnt   = 8'd0;
    logic [7:0]  rx_hi     = 8'd0;

    t_result     expected_q[$];

    // Stimulus shaping
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;

    // Run statistics and failures
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_closed = 0;
    int unsigned good_frames   = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;

    always #6 i_clk = ~i_clk;

    sonde_frame_descramble_checksum uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // One rotate/XOR step of the running frame checksum
    function automatic logic [15:0] checksum_step(input logic [15:0] acc, input logic [7:0] data);
        logic [7:0] rot;
        logic [7:0] mix;
        logic [7:0] hi;
        rot = {data[0], data[7:1]};
        rot = rot ^ (rot >> 2);
        mix = {^{acc[5], acc[3], acc[1]}, ^{acc[4], acc[2], acc[0]}, acc[5:0]};
        hi  = acc[14:7];
        hi  = hi ^ (hi >> 2);
        return {acc[7:0], rot ^ mix ^ hi};
    endfunction

    // Invert the descrambler: find the raw byte that yields a wanted plain byte
    function automatic logic [7:0] scramble(input logic [7:0] plain, input logic prev);
        logic [7:0] raw;
        raw[7] = ~(plain[7] ^ prev);
        for (int i = 6; i >= 0; i--)
            raw[i] = ~(plain[i] ^ raw[i + 1]);
        return raw;
    endfunction

    task automatic clear_frame_state();
        chain_bit = 1'b0;
        sum_acc   = 16'd0;
        pos_cnt   = 8'd0;
        rx_hi     = 8'd0;
    endtask

    // Work out the result of one accepted byte and queue it
    task automatic descramble_predict(input logic [7:0] raw, input logic start);
        t_result r;
        int      eff;
        eff = (len_reg < FRAME_LEN_MIN) ? int'(FRAME_LEN_MIN) : int'(len_reg);
        if (start)
            clear_frame_state();
        r.plain   = raw ^ SCRAMBLE_MASK ^ {chain_bit, raw[7:1]};
        chain_bit = raw[0];
        r.last    = 1'b0;
        r.good    = 1'b0;
        if (int'(pos_cnt) + 1 >= eff) begin
            r.last = 1'b1;
            r.good = ({rx_hi, r.plain} == sum_acc);
            clear_frame_state();
        end else begin
            if (int'(pos_cnt) + 2 < eff)
                sum_acc = checksum_step(sum_acc, r.plain);
            else
                rx_hi = r.plain;
            pos_cnt = pos_cnt + 8'd1;
        end
        expected_q.push_back(r);
    endtask

    // Offer one byte, hold it until accepted; valid stays up for a following beat
    task automatic send_byte(input logic [7:0] raw, input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= raw;
        s_user  <= start;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        descramble_predict(raw, start);
        items_sent++;
    endtask

    // Send a frame whose last two bytes carry its checksum, optionally with one bad bit
    task automatic send_frame(input int unsigned len, input bit with_start, input bit corrupt);
        logic [15:0] sum;
        logic [7:0]  plain;
        logic [7:0]  raw;
        logic        chain;
        int unsigned bad_at;
        sum    = 16'd0;
        chain  = 1'b0;
        bad_at = corrupt ? $urandom_range(len - 1) : len;
        for (int unsigned k = 0; k < len; k++) begin
            if (k + 2 < len) begin
                plain = 8'($urandom);
                sum   = checksum_step(sum, plain);
            end else if (k + 2 == len) begin
                plain = sum[15:8];
            end else begin
                plain = sum[7:0];
            end
            raw = scramble(plain, chain);
            if (k == bad_at)
                raw[$urandom_range(7)] ^= 1'b1;
            chain = raw[0];
            send_byte(raw, with_start && (k == 0));
        end
    endtask

    // Drop valid and let every outstanding result come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_length(input logic [7:0] value);
        wait_idle();
        cfg_en   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_en   <= 1'b0;
        len_reg = value;
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("tb_top: mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                     what, results_seen, want, got);
    endtask

    // Receiver: check each result beat, then pick the next tready
    always @(posedge i_clk) begin : result_side
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", 0, o_m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                if (o_m_axis_tdata !== want.plain)
                    report_mismatch("plain_byte", want.plain, o_m_axis_tdata);
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("last_of_frame", want.last, o_m_axis_tlast);
                if (o_m_axis_tuser !== want.good)
                    report_mismatch("checksum_good", want.good, o_m_axis_tuser);
            end
            results_seen++;
            if (o_m_axis_tlast === 1'b1)
                frames_closed++;
            if (o_m_axis_tuser === 1'b1)
                good_frames++;
        end
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: give up after a long run of cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Frames at the length that reset leaves in place
    task automatic test_reset_length();
        send_frame(FRAME_LEN_RESET, 1'b1, 1'b0);
        send_frame(FRAME_LEN_RESET, 1'b0, 1'b0);
    endtask

    // Shortest frames: one of all-zero and all-one raw bytes, then a well-formed one
    task automatic test_field_extremes();
        write_frame_length(FRAME_LEN_MIN);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_frame(FRAME_LEN_MIN, 1'b0, 1'b0);
    endtask

    // Lengths below the minimum behave as the minimum
    task automatic test_short_length();
        write_frame_length(8'd0);
        send_frame(4, 1'b1, 1'b0);
        write_frame_length(8'd3);
        send_frame(4, 1'b0, 1'b1);
    endtask

    // A frame start in the middle of a frame drops the partial frame
    task automatic test_restart_mid_frame();
        write_frame_length(FRAME_LEN_MIN);
        send_byte(8'($urandom), 1'b1);
        send_byte(8'($urandom), 1'b0);
        send_frame(4, 1'b1, 1'b0);
    endtask

    // Lowering the length past the current position closes the frame on the next byte
    task automatic test_length_lowered();
        write_frame_length(8'd255);
        send_frame(6, 1'b1, 1'b0);
        write_frame_length(8'd5);
        send_byte(8'($urandom), 1'b0);
    endtask

    // Hold the receiver off while the sender keeps pushing, so the input stalls
    task automatic test_output_backpressure();
        write_frame_length(8'd12);
        hold_req <= hold_req + 1;
        send_frame(12, 1'b1, 1'b0);
        send_frame(12, 1'b1, 1'b1);
    endtask

    // Mostly well-formed frames at random lengths, some broken, cut short or noise
    task automatic test_random_frames(input int unsigned item_goal);
        int unsigned goal_end;
        int unsigned len_pick;
        int unsigned eff;
        int unsigned nframes;
        int unsigned roll;
        goal_end = items_sent + item_goal;
        while (items_sent < goal_end) begin
            roll = $urandom_range(99);
            if (roll < 72)
                len_pick = $urandom_range(4, 20);
            else if (roll < 80)
                len_pick = $urandom_range(21, 254);
            else if (roll < 83)
                len_pick = 255;
            else
                len_pick = $urandom_range(0, 3);
            write_frame_length(len_pick[7:0]);
            eff     = (len_pick < 4) ? 4 : len_pick;
            nframes = (eff > 20) ? 1 : $urandom_range(2, 6);
            repeat (nframes) begin
                roll = $urandom_range(99);
                if (roll < 65)
                    send_frame(eff, 1'b1, 1'b0);
                else if (roll < 75)
                    send_frame(eff, 1'b0, 1'b0);
                else if (roll < 85)
                    send_frame(eff, 1'b1, 1'b1);
                else if (roll < 93)
                    send_frame($urandom_range(1, eff - 1), 1'b1, 1'b0);
                else
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender mostly busy, receiver stalls about half the time
        src_idle_pct  = 6;
        sink_idle_pct = 51;
        test_reset_length();
        test_field_extremes();
        test_short_length();
        test_restart_mid_frame();
        test_length_lowered();
        test_output_backpressure();
        test_random_frames(500);

        // Sender gappy, receiver mostly ready
        src_idle_pct  = 51;
        sink_idle_pct = 6;
        test_random_frames(500);

        // Full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_frames(500);

        wait_idle();
        $display("tb_top: %0d bytes sent, %0d results checked, %0d frames closed",
                 items_sent, results_seen, frames_closed);
        $display("tb_top: %0d good checksums, %0d mismatches", good_frames, error_count);
        if (error_count == 0 && expected_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
